// ===== rtl/core/hpp_pkg.sv =====
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types, character codes and helper functions for the hex pattern parser
// ----------------------------------------------------------------------------
package hpp_pkg;

	localparam logic [15:0] CU_SPACE    = 16'h0020;
	localparam logic [15:0] CU_QUOTE    = 16'h0022;
	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	// parser state
	typedef struct packed {
		logic       in_quote;
		logic       surrogate_pending;
		logic [9:0] surrogate_high_bits;
		logic       nibble_pending;
		logic [3:0] held_nibble;
		logic       error_seen;
	} parse_state_t;

	// every result caused by one request
	typedef struct packed {
		logic [2:0]          cnt;
		logic [3:0][7:0]     bytes;
		logic                has0;
		logic                fin;
		logic                fail;
	} bundle_t;

	// hand-off from parser to emitter
	typedef struct packed {
		logic    load;
		bundle_t bundle;
	} emit_req_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [15:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'h0;
		if (c >= 16'h0030 && c <= 16'h0039) begin
			r.val = c[3:0];
		end else if ((c >= 16'h0061 && c <= 16'h0066) ||
				(c >= 16'h0041 && c <= 16'h0046)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic bundle_t utf8_encode(input logic [20:0] s);
		bundle_t b;
		b      = '0;
		b.has0 = 1'b1;
		if (s <= 21'h7F) begin
			b.cnt      = 3'd1;
			b.bytes[0] = s[7:0];
		end else if (s <= 21'h7FF) begin
			b.cnt      = 3'd2;
			b.bytes[0] = {3'b110, s[10:6]};
			b.bytes[1] = {2'b10, s[5:0]};
		end else if (s <= 21'hFFFF) begin
			b.cnt      = 3'd3;
			b.bytes[0] = {4'b1110, s[15:12]};
			b.bytes[1] = {2'b10, s[11:6]};
			b.bytes[2] = {2'b10, s[5:0]};
		end else begin
			b.cnt      = 3'd4;
			b.bytes[0] = {5'b11110, s[20:18]};
			b.bytes[1] = {2'b10, s[17:12]};
			b.bytes[2] = {2'b10, s[11:6]};
			b.bytes[3] = {2'b10, s[5:0]};
		end
		return b;
	endfunction

endpackage

// ===== rtl/core/hex_pattern_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_pattern_parser_top
// Streaming parser of byte-pattern text given as UTF-16 code units
// ----------------------------------------------------------------------------
// each request carries one UTF-16 code unit of the pattern text, or an end
// marker. outside quotes, hex tokens of one or two digits become bytes and
// spaces separate tokens; inside quotes, code units (surrogate pairs joined)
// come out as UTF-8 bytes. an end request always yields exactly one finishing
// result that says whether the pattern was valid; on failure the consumer
// drops the bytes it took since the previous end. a request is decoded in the
// cycle it is accepted and all its results (zero to four) land in one result
// register, which hands them out one per cycle while out_stall is low. a
// request with zero or one result lets a new one be taken every cycle while
// out_stall is low; a quoted character of more than one UTF-8 byte holds in_stall
// while the result register drains. no clearing pass after reset.
module hex_pattern_parser_top import hpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] code_unit,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic        has_byte,
	output logic        last,
	output logic        finished,
	output logic        failed
);

	emit_req_t req;
	logic      can_load;
	logic      accept;

	// take a request whenever the result register is free or just emptying
	assign in_stall = !can_load;
	assign accept   = in_valid && can_load;

	// decode and state update
	hpp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.code_unit (code_unit),
		.req       (req)
	);

	// result register and byte serializer
	hpp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.can_load  (can_load),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.finished  (finished),
		.failed    (failed),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

// ===== rtl/core/hpp_parse.sv =====
// ----------------------------------------------------------------------------
// hpp_parse
// Parser state and per-request decode into a bundle of up to four results
// ----------------------------------------------------------------------------
module hpp_parse import hpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        action,
	input  logic [15:0] code_unit,
	output emit_req_t   req
);

	parse_state_t st_q;
	parse_state_t st_nxt;
	bundle_t      b;
	hex_t         hv;
	logic         is_hi;
	logic         is_lo;
	logic         fail;

	assign hv    = hex_value(code_unit);
	assign is_hi = code_unit >= SURR_HI_MIN && code_unit <= SURR_HI_MAX;
	assign is_lo = code_unit >= SURR_LO_MIN && code_unit <= SURR_LO_MAX;
	assign fail  = st_q.error_seen | st_q.in_quote | st_q.surrogate_pending;

	always_comb begin
		st_nxt = st_q;
		b      = '0;
		if (action) begin
			b.cnt  = 3'd1;
			b.fin  = 1'b1;
			b.fail = fail;
			if (!fail && st_q.nibble_pending) begin
				b.has0     = 1'b1;
				b.bytes[0] = {4'h0, st_q.held_nibble};
			end
			st_nxt = '0;
		end else if (!st_q.error_seen) begin
			if (st_q.in_quote) begin
				if (st_q.surrogate_pending) begin
					st_nxt.surrogate_pending = 1'b0;
					if (is_lo) begin
						b = utf8_encode({1'b0, st_q.surrogate_high_bits, code_unit[9:0]}
							+ SUPP_BASE);
					end else begin
						st_nxt.error_seen = 1'b1;
					end
				end else if (code_unit == CU_QUOTE) begin
					st_nxt.in_quote = 1'b0;
				end else if (is_hi) begin
					st_nxt.surrogate_pending   = 1'b1;
					st_nxt.surrogate_high_bits = code_unit[9:0];
				end else if (is_lo) begin
					st_nxt.error_seen = 1'b1;
				end else begin
					b = utf8_encode({5'b0, code_unit});
				end
			end else begin
				if (code_unit == CU_SPACE || code_unit == CU_QUOTE) begin
					if (st_q.nibble_pending) begin
						b.cnt      = 3'd1;
						b.has0     = 1'b1;
						b.bytes[0] = {4'h0, st_q.held_nibble};
						st_nxt.nibble_pending = 1'b0;
					end
					if (code_unit == CU_QUOTE) begin
						st_nxt.in_quote = 1'b1;
					end
				end else if (!hv.ok) begin
					st_nxt.error_seen = 1'b1;
				end else if (st_q.nibble_pending) begin
					b.cnt      = 3'd1;
					b.has0     = 1'b1;
					b.bytes[0] = {st_q.held_nibble, hv.val};
					st_nxt.nibble_pending = 1'b0;
				end else begin
					st_nxt.nibble_pending = 1'b1;
					st_nxt.held_nibble    = hv.val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	assign req.load   = accept && (b.cnt != 3'd0);
	assign req.bundle = b;

endmodule

// ===== rtl/core/hpp_emit.sv =====
// ----------------------------------------------------------------------------
// hpp_emit
// Result register that serializes a bundle one result per handshake
// ----------------------------------------------------------------------------
module hpp_emit import hpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  emit_req_t   req,
	output logic        can_load,
	output logic [7:0]  data_byte,
	output logic        has_byte,
	output logic        last,
	output logic        finished,
	output logic        failed,
	output logic        out_valid,
	input  logic        out_stall
);

	bundle_t    bundle_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       out_fire;
	logic       done;

	assign out_valid = busy_q;
	assign out_fire  = busy_q && !out_stall;
	assign last      = ({1'b0, idx_q} == (bundle_q.cnt - 3'd1));
	assign done      = out_fire && last;
	// a new bundle may land as the old one drains its final result
	assign can_load  = !busy_q || done;

	assign data_byte = bundle_q.bytes[idx_q];
	assign has_byte  = (idx_q == 2'd0) ? bundle_q.has0 : 1'b1;
	assign finished  = bundle_q.fin;
	assign failed    = bundle_q.fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (req.load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			bundle_q <= req.bundle;
		end
	end

endmodule

// ===== rtl/core/hpp_checker.sv =====
// ----------------------------------------------------------------------------
// hpp_checker
// Port-level checks of the hex pattern parser, bound to the top level
// ----------------------------------------------------------------------------
module hpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  data_byte,
	input logic        has_byte,
	input logic        last,
	input logic        finished,
	input logic        failed
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(last)
			&& $stable(finished))
		else $error("stalled result changed");

	// an accepted end request shows its finishing result next cycle
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> out_valid && finished && last)
		else $error("end request did not finish");

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> last)
		else $error("finishing result not last");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> finished && !has_byte && data_byte == 8'h00)
		else $error("failed result carries a byte");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> has_byte)
		else $error("plain result without byte");

endmodule

bind hex_pattern_parser_top hpp_checker u_hpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_byte (data_byte),
	.has_byte  (has_byte),
	.last      (last),
	.finished  (finished),
	.failed    (failed)
);
